// File: hw/rtl/text_record_hex_loader_core_macros.svh
// assertion helpers for the loader rtl
`ifndef TEXT_RECORD_HEX_LOADER_CORE_MACROS_SVH
`define TEXT_RECORD_HEX_LOADER_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define TRHL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define TRHL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/trhl_pkg.sv
`default_nettype none

package trhl_pkg;

   // address space width default
   localparam int unsigned ADDR_BITS_DEFAULT = 16;

   // field widths of the stream words
   localparam int unsigned CHAR_W     = 8;
   localparam int unsigned RSP_ADDR_W = 16;
   localparam int unsigned RSP_DATA_W = 8;
   localparam int unsigned NIBBLE_W   = 4;

   // characters with a meaning to the loader
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_DELIM   = 8'h5E;
   localparam logic [CHAR_W-1:0] CHAR_T       = 8'h54;
   localparam logic [CHAR_W-1:0] CHAR_E       = 8'h45;
   localparam logic [CHAR_W-1:0] CHAR_H       = 8'h48;

   // token positions within a text record
   localparam logic [1:0] TOK_MARK    = 2'd0;
   localparam logic [1:0] TOK_ADDRESS = 2'd1;
   localparam logic [1:0] TOK_LENGTH  = 2'd2;
   localparam logic [1:0] TOK_DATA    = 2'd3;

   // result kinds
   typedef enum logic {
      KIND_WRITE = 1'b0,
      KIND_END   = 1'b1
   } kind_type;

   // where we are within a line
   typedef enum logic [1:0] {
      PHASE_START = 2'd0,
      PHASE_TEXT  = 2'd1,
      PHASE_SKIP  = 2'd2
   } phase_type;

   // hex digit decode
   typedef struct packed {
      logic                valid;
      logic [NIBBLE_W-1:0] value;
   } hex_type;

   function automatic hex_type hex_decode(input logic [CHAR_W-1:0] c);
      hex_type h;
      h.valid = 1'b1;
      h.value = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.value = NIBBLE_W'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         h.value = NIBBLE_W'(c - 8'h37);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         h.value = NIBBLE_W'(c - 8'h57);
      end else begin
         h.valid = 1'b0;
      end
      return h;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/text_record_hex_loader_core.sv
`default_nettype none

// Absolute loader for object-program text, one character per input word.
// Each accepted character is decoded and the line state updated in the same
// cycle; a byte write or the end marker, when the character causes one, lands
// in the result register, which is the only stage. One character is taken
// every cycle as long as the result register is empty or being drained, so
// throughput is one word per clock; the result appears in the cycle after
// acceptance. After an 'E' line the end result is sent and all further input is
// consumed and dropped until reset. Addresses wrap at 2**ADDR_BITS; the
// result carries the low 16 bits of the address.
`include "text_record_hex_loader_core_macros.svh"

module text_record_hex_loader_core
   import trhl_pkg::*;
#(
   parameter int unsigned ADDR_BITS = ADDR_BITS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request stream
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [CHAR_W-1:0]                  req_tdata,  // [7:0] character
   // result stream
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [RSP_ADDR_W+RSP_DATA_W-1:0]        rsp_tdata,  // [15:0] write_address,
                                                               // [23:16] write_data
   output logic                                    rsp_tuser   // [0] kind
);

   // line and token state
   phase_type               phase_ff, phase_in;
   logic [1:0]              token_ff, token_in;
   logic                    inside_ff, inside_in;
   logic [ADDR_BITS-1:0]    load_ff, load_in;
   logic [ADDR_BITS-1:0]    start_ff, start_in;
   logic [NIBBLE_W-1:0]     pair_value_ff, pair_value_in;
   logic                    pair_half_ff, pair_half_in;
   logic                    pair_frozen_ff, pair_frozen_in;
   logic                    finished_ff, finished_in;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   kind_type                rsp_kind_ff, rsp_kind_in;
   logic [RSP_ADDR_W-1:0]   rsp_addr_ff, rsp_addr_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   logic                    req_accept;
   logic                    emit;
   kind_type                emit_kind;
   logic [RSP_ADDR_W-1:0]   emit_addr;
   logic [RSP_DATA_W-1:0]   emit_data;
   hex_type                 hex;
   logic                    half_v;
   logic                    frozen_v;
   logic [NIBBLE_W-1:0]     value_v;
   logic                    stop_char;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   assign hex       = hex_decode(req_tdata);
   assign stop_char = (req_tdata == CHAR_E) || (req_tdata == CHAR_H) ||
                      (req_tdata == CHAR_T);

   // per-character decode and next line state
   always_comb begin
      phase_in       = phase_ff;
      token_in       = token_ff;
      inside_in      = inside_ff;
      load_in        = load_ff;
      start_in       = start_ff;
      pair_value_in  = pair_value_ff;
      pair_half_in   = pair_half_ff;
      pair_frozen_in = pair_frozen_ff;
      finished_in    = finished_ff;
      emit           = 1'b0;
      emit_kind      = KIND_WRITE;
      emit_addr      = RSP_ADDR_W'(load_ff);
      emit_data      = '0;
      half_v         = pair_half_ff;
      frozen_v       = pair_frozen_ff;
      value_v        = pair_value_ff;
      if (!finished_ff) begin
         unique case (phase_ff)
            PHASE_START: begin
               token_in       = TOK_MARK;
               inside_in      = 1'b0;
               pair_half_in   = 1'b0;
               pair_frozen_in = 1'b0;
               pair_value_in  = '0;
               if (req_tdata == CHAR_NEWLINE) begin
                  phase_in = PHASE_START;
               end else if (req_tdata == CHAR_E) begin
                  finished_in = 1'b1;
                  emit        = 1'b1;
                  emit_kind   = KIND_END;
                  emit_addr   = '0;
               end else if (req_tdata == CHAR_T) begin
                  phase_in  = PHASE_TEXT;
                  inside_in = 1'b1;
               end else begin
                  phase_in = PHASE_SKIP;
               end
            end
            PHASE_SKIP: begin
               if (req_tdata == CHAR_NEWLINE) begin
                  phase_in = PHASE_START;
               end
            end
            PHASE_TEXT: begin
               if (req_tdata == CHAR_NEWLINE || req_tdata == CHAR_DELIM) begin
                  // token end: latch or recall the address, or flush an odd digit
                  if (inside_ff) begin
                     if (token_ff == TOK_ADDRESS) begin
                        if (pair_half_ff) begin
                           start_in = load_ff;
                        end else begin
                           load_in = start_ff;
                        end
                     end else if (token_ff == TOK_DATA && pair_half_ff) begin
                        emit      = 1'b1;
                        emit_data = pair_frozen_ff ? '0 : RSP_DATA_W'(pair_value_ff);
                        load_in   = load_ff + ADDR_BITS'(1);
                     end
                     pair_half_in   = 1'b0;
                     pair_frozen_in = 1'b0;
                     pair_value_in  = '0;
                     inside_in      = 1'b0;
                     if (token_ff != TOK_DATA) begin
                        token_in = token_ff + 2'd1;
                     end
                  end
                  if (req_tdata == CHAR_NEWLINE) begin
                     phase_in = PHASE_START;
                  end
               end else if (!inside_ff && token_ff == TOK_DATA && stop_char) begin
                  // stop token ends the record
                  inside_in      = 1'b0;
                  pair_half_in   = 1'b0;
                  pair_frozen_in = 1'b0;
                  pair_value_in  = '0;
                  phase_in       = PHASE_SKIP;
               end else begin
                  // token start clears the pair
                  if (!inside_ff) begin
                     half_v   = 1'b0;
                     frozen_v = 1'b0;
                     value_v  = '0;
                  end
                  inside_in      = 1'b1;
                  pair_half_in   = half_v;
                  pair_frozen_in = frozen_v;
                  pair_value_in  = value_v;
                  case (token_ff)
                     TOK_ADDRESS: begin
                        if (!frozen_v) begin
                           if (!hex.valid) begin
                              pair_frozen_in = 1'b1;
                           end else if (!half_v) begin
                              load_in      = ADDR_BITS'(hex.value);
                              pair_half_in = 1'b1;
                           end else begin
                              load_in = {load_ff[ADDR_BITS-NIBBLE_W-1:0], hex.value};
                           end
                        end
                     end
                     TOK_DATA: begin
                        if (!half_v) begin
                           pair_half_in   = 1'b1;
                           pair_frozen_in = !hex.valid;
                           pair_value_in  = hex.valid ? hex.value : '0;
                        end else begin
                           emit = 1'b1;
                           if (frozen_v) begin
                              emit_data = '0;
                           end else if (!hex.valid) begin
                              emit_data = RSP_DATA_W'(value_v);
                           end else begin
                              emit_data = {value_v, hex.value};
                           end
                           load_in        = load_ff + ADDR_BITS'(1);
                           pair_half_in   = 1'b0;
                           pair_frozen_in = 1'b0;
                           pair_value_in  = '0;
                        end
                     end
                     default: begin
                        // mark and length tokens carry nothing
                        pair_half_in = half_v;
                     end
                  endcase
               end
            end
            default: begin
               phase_in = PHASE_START;
            end
         endcase
      end
   end

   // result register next value
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_data_in  = rsp_data_ff;
      if (req_accept) begin
         rsp_valid_in = emit;
         if (emit) begin
            rsp_kind_in = emit_kind;
            rsp_addr_in = emit_addr;
            rsp_data_in = emit_data;
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control and line state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PHASE_START;
         token_ff       <= TOK_MARK;
         inside_ff      <= 1'b0;
         load_ff        <= '0;
         start_ff       <= '0;
         pair_value_ff  <= '0;
         pair_half_ff   <= 1'b0;
         pair_frozen_ff <= 1'b0;
         finished_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (req_accept) begin
            phase_ff       <= phase_in;
            token_ff       <= token_in;
            inside_ff      <= inside_in;
            load_ff        <= load_in;
            start_ff       <= start_in;
            pair_value_ff  <= pair_value_in;
            pair_half_ff   <= pair_half_in;
            pair_frozen_ff <= pair_frozen_in;
            finished_ff    <= finished_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_kind_ff <= rsp_kind_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_data_ff, rsp_addr_ff};
   assign rsp_tuser  = rsp_kind_ff;

   // checks
   `TRHL_ASSERT_NEXT(a_finished_sticks, clock, reset, finished_ff, finished_ff, "loader left finished state")
   `TRHL_ASSERT_NOW(a_end_sets_finished, clock, reset, rsp_valid_ff && rsp_kind_ff == KIND_END, finished_ff, "end result without finished state")
   `TRHL_ASSERT_NOW(a_mark_token_open, clock, reset, phase_ff == PHASE_TEXT && token_ff == TOK_MARK, inside_ff, "record mark token closed without advance")
   `TRHL_ASSERT_NOW(a_data_frozen_half, clock, reset, token_ff == TOK_DATA && pair_frozen_ff, pair_half_ff, "frozen data pair without first half")

endmodule

`default_nettype wire

// File: bench/text_record_hex_loader_checker.sv
module text_record_hex_loader_checker
   import trhl_pkg::*;
(
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [CHAR_W-1:0]                  req_tdata,   // [7:0] character
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [RSP_ADDR_W+RSP_DATA_W-1:0]   rsp_tdata,   // [15:0] write_address,
                                                           // [23:16] write_data
   input  logic                               rsp_tuser,   // [0] kind
   output int                                 fail_count,
   output int                                 pending_count
);

   localparam int PRINT_LIMIT = 40;

   // one word the loader should send
   typedef struct packed {
      kind_type                kind;
      logic [RSP_ADDR_W-1:0]   address;
      logic [RSP_DATA_W-1:0]   data;
   } load_word_type;

   load_word_type due_writes[$];

   // shadow of the loader state
   phase_type               line_phase;
   logic [1:0]              tok_idx;
   bit                      in_tok;
   logic [RSP_ADDR_W-1:0]   load_addr;
   logic [RSP_ADDR_W-1:0]   record_base;
   logic [RSP_DATA_W-1:0]   pair_val;
   bit                      pair_half;
   bit                      pair_frozen;
   bit                      load_done;

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   task automatic flag_mismatch(input string msg);
      if (fail_count < PRINT_LIMIT) begin
         $display("[%0t] loader mismatch: %s", $realtime, msg);
      end
      fail_count++;
   endtask

   function automatic bit hex_digit(input logic [7:0] c, output logic [3:0] v);
      v = 4'h0;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = c[3:0];
         return 1'b1;
      end
      if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         v = c[3:0] + 4'd9;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic clear_pair();
      pair_half   = 1'b0;
      pair_frozen = 1'b0;
      pair_val    = '0;
   endtask

   task automatic clear_state();
      line_phase  = PHASE_START;
      tok_idx     = TOK_MARK;
      in_tok      = 1'b0;
      load_addr   = '0;
      record_base = '0;
      load_done   = 1'b0;
      clear_pair();
   endtask

   // byte write at the running address, which then wraps forward
   task automatic push_write(input logic [RSP_DATA_W-1:0] value);
      load_word_type w;
      w.kind    = KIND_WRITE;
      w.address = load_addr;
      w.data    = value;
      due_writes.push_back(w);
      load_addr = load_addr + RSP_ADDR_W'(1);
      clear_pair();
   endtask

   // token end: latch or recall the record address, flush an odd data digit
   task automatic close_token();
      if (!in_tok) return;
      if (tok_idx == TOK_ADDRESS) begin
         if (pair_half) record_base = load_addr;
         else load_addr = record_base;
      end else if (tok_idx == TOK_DATA && pair_half) begin
         push_write(pair_frozen ? '0 : pair_val);
      end
      clear_pair();
      in_tok = 1'b0;
      if (tok_idx != TOK_DATA) tok_idx = tok_idx + 2'd1;
   endtask

   // advance the shadow state by one accepted character
   task automatic absorb_char(input logic [CHAR_W-1:0] c);
      load_word_type w;
      logic [3:0] nib;
      bit         is_hex;
      if (load_done) return;
      case (line_phase)
         PHASE_START: begin
            tok_idx = TOK_MARK;
            in_tok  = 1'b0;
            clear_pair();
            if (c == CHAR_NEWLINE) return;
            if (c == CHAR_E) begin
               load_done = 1'b1;
               w.kind    = KIND_END;
               w.address = '0;
               w.data    = '0;
               due_writes.push_back(w);
               return;
            end
            if (c == CHAR_T) begin
               line_phase = PHASE_TEXT;
               in_tok     = 1'b1;
            end else begin
               line_phase = PHASE_SKIP;
            end
            return;
         end
         PHASE_SKIP: begin
            if (c == CHAR_NEWLINE) line_phase = PHASE_START;
            return;
         end
         default: begin
            if (c == CHAR_NEWLINE || c == CHAR_DELIM) begin
               close_token();
               if (c == CHAR_NEWLINE) line_phase = PHASE_START;
               return;
            end
            // first character of a token; a data token led by E, H or T stops the record
            if (!in_tok) begin
               in_tok = 1'b1;
               clear_pair();
               if (tok_idx == TOK_DATA && (c == CHAR_E || c == CHAR_H || c == CHAR_T)) begin
                  in_tok     = 1'b0;
                  line_phase = PHASE_SKIP;
                  return;
               end
            end
            is_hex = hex_digit(c, nib);
            if (tok_idx == TOK_ADDRESS) begin
               // leading hex digits only, kept modulo the address space
               if (!pair_frozen) begin
                  if (!is_hex) begin
                     pair_frozen = 1'b1;
                  end else if (!pair_half) begin
                     load_addr = {{(RSP_ADDR_W-4){1'b0}}, nib};
                     pair_half = 1'b1;
                  end else begin
                     load_addr = {load_addr[RSP_ADDR_W-5:0], nib};
                  end
               end
            end else if (tok_idx == TOK_DATA) begin
               if (!pair_half) begin
                  pair_half = 1'b1;
                  if (!is_hex) begin
                     pair_frozen = 1'b1;
                     pair_val    = '0;
                  end else begin
                     pair_val = {4'h0, nib};
                  end
               end else if (pair_frozen) begin
                  push_write('0);
               end else if (!is_hex) begin
                  push_write(pair_val);
               end else begin
                  push_write({pair_val[3:0], nib});
               end
            end
         end
      endcase
   endtask

   // predict on every accepted character, compare every accepted result word
   always @(posedge clock) begin : watch
      load_word_type exp_w;
      if (reset) begin
         clear_state();
         due_writes.delete();
      end else begin
         if (req_tvalid && req_tready) absorb_char(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (due_writes.size() == 0) begin
               flag_mismatch($sformatf("unexpected word kind=%0d addr=%h data=%h",
                             rsp_tuser, rsp_tdata[RSP_ADDR_W-1:0],
                             rsp_tdata[RSP_ADDR_W +: RSP_DATA_W]));
            end else begin
               exp_w = due_writes.pop_front();
               if (rsp_tuser !== exp_w.kind)
                  flag_mismatch($sformatf("kind %0d, expected %0d", rsp_tuser, exp_w.kind));
               if (rsp_tdata[RSP_ADDR_W-1:0] !== exp_w.address)
                  flag_mismatch($sformatf("write_address %h, expected %h",
                                rsp_tdata[RSP_ADDR_W-1:0], exp_w.address));
               if (rsp_tdata[RSP_ADDR_W +: RSP_DATA_W] !== exp_w.data)
                  flag_mismatch($sformatf("write_data %h, expected %h at address %h",
                                rsp_tdata[RSP_ADDR_W +: RSP_DATA_W], exp_w.data,
                                exp_w.address));
            end
         end
      end
      pending_count = due_writes.size();
   end

endmodule

// File: bench/tb_text_record_hex_loader_core.sv
module tb_text_record_hex_loader_core;
   import trhl_pkg::*;

   localparam int CHAR_TARGET    = 400;
   localparam int WATCHDOG_LIMIT = 500;
   localparam int DRAIN_CYCLES   = 4;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [CHAR_W-1:0]                req_tdata = '0;      // [7:0] character
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [RSP_ADDR_W+RSP_DATA_W-1:0] rsp_tdata;           // [15:0] write_address,
                                                          // [23:16] write_data
   logic                             rsp_tuser;           // [0] kind
   int                               fail_count;
   int                               pending_count;
   int                               chars_sent = 0;
   int                               idle_cycles = 0;
   bit                               send_calm = 1'b0;

   // clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   text_record_hex_loader_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   text_record_hex_loader_checker loader_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // watchdog on cycles with no word moving on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** text_record_hex_loader_core: FAILED **");
            $finish;
         end
      end
   end

   // result side: random stall before each word, with calm stretches
   initial begin : drain
      int stall;
      int taken;
      bit calm;
      taken = 0;
      calm  = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (taken % 32 == 0) calm = ($urandom_range(0, 3) == 0);
         stall = calm ? 0 : $urandom_range(0, 8);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         taken++;
         @(negedge clock);
      end
   end

   // one character word, after a drawn gap
   task automatic send_char(input logic [7:0] c);
      int gap;
      if (chars_sent % 32 == 0) send_calm = ($urandom_range(0, 3) == 0);
      gap = send_calm ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= c;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      chars_sent++;
      @(negedge clock);
   endtask

   task automatic send_str(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
   endtask

   function automatic bit is_hex_char(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
   endfunction

   // any byte that does not end the line
   function automatic logic [7:0] noise_byte();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (c == CHAR_NEWLINE);
      return c;
   endfunction

   // a byte that stays inside the token but is not a hex digit
   function automatic logic [7:0] junk_byte();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while (c == CHAR_NEWLINE || c == CHAR_DELIM || is_hex_char(c));
      return c;
   endfunction

   // hex digit in either case
   function automatic logic [7:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) return 8'h30 + v;
      return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 8'd10;
   endfunction

   // random hex digit character
   function automatic logic [7:0] rand_hex_char();
      return hex_char(4'($urandom_range(0, 15)));
   endfunction

   task automatic send_delims();
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1) send_char(CHAR_DELIM);
   endtask

   // well-formed text record with random content and some damage
   task automatic send_text_record();
      int n_data;
      int tok_len;
      int pick;
      send_char(CHAR_T);
      if ($urandom_range(0, 9) == 0) send_char(junk_byte());
      send_delims();
      // start address, sometimes missing or cut by a stray character
      if ($urandom_range(0, 9) == 0) begin
         send_char(junk_byte());
      end else begin
         repeat ($urandom_range(1, 6)) send_char(rand_hex_char());
         if ($urandom_range(0, 9) == 0) begin
            send_char(junk_byte());
            send_char(rand_hex_char());
         end
      end
      send_delims();
      repeat ($urandom_range(0, 2)) send_char(rand_hex_char());
      n_data = $urandom_range(0, 4);
      for (int t = 0; t < n_data; t++) begin
         send_delims();
         pick = $urandom_range(0, 11);
         if (pick == 0) begin
            // stop token
            case ($urandom_range(0, 2))
               0: send_char(CHAR_E);
               1: send_char(CHAR_H);
               default: send_char(CHAR_T);
            endcase
            repeat ($urandom_range(0, 3)) send_char(rand_hex_char());
         end else begin
            tok_len = $urandom_range(1, 10);
            repeat (tok_len) begin
               if ($urandom_range(0, 11) == 0) send_char(junk_byte());
               else send_char(rand_hex_char());
            end
         end
      end
      if ($urandom_range(0, 4) == 0) send_delims();
      send_char(CHAR_NEWLINE);
   endtask

   // stimulus and verdict
   initial begin : stimulus
      int pick;
      logic [7:0] first;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: header skip, delimiter run, long address, odd digit,
      // non-hex first and second characters, stop token, recalled address
      send_str("H\n");
      send_str("T^^12345^x^a1Zz3^E\n");
      send_str("T^q^0^4g\n");

      // random lines, never opening with the end mark
      while (chars_sent < CHAR_TARGET) begin
         pick = $urandom_range(0, 9);
         if (pick <= 6) begin
            send_text_record();
         end else if (pick == 7) begin
            send_char(CHAR_H);
            repeat ($urandom_range(0, 12)) send_char(noise_byte());
            send_char(CHAR_NEWLINE);
         end else if (pick == 8) begin
            do first = noise_byte(); while (first == CHAR_E);
            send_char(first);
            repeat ($urandom_range(0, 12)) send_char(noise_byte());
            send_char(CHAR_NEWLINE);
         end else begin
            // empty line or a text record cut to noise
            if ($urandom_range(0, 1)) begin
               send_char(CHAR_T);
               repeat ($urandom_range(0, 10)) send_char(noise_byte());
            end
            send_char(CHAR_NEWLINE);
         end
      end

      // end record, then input that must be dropped
      send_str("E\n");
      send_str("T^10^2^ABCD\n");
      req_tvalid <= 1'b0;

      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("** text_record_hex_loader_core: PASSED **");
      end else begin
         $display("** text_record_hex_loader_core: FAILED **");
      end
      $finish;
   end

endmodule

// File: text_record_hex_loader_core.f
+incdir+hw/rtl
hw/rtl/trhl_pkg.sv
hw/rtl/text_record_hex_loader_core.sv
bench/text_record_hex_loader_checker.sv
bench/tb_text_record_hex_loader_core.sv
